FILE: rtl/gcbb_pkg.sv
// shared types and constants for the glyph coverage blend blitter
package gcbb_pkg;

   typedef logic [15:0] rgb565_type;
   typedef logic [31:0] lane_type;
   typedef logic [3:0]  coverage_type;
   typedef logic [3:0]  csr_index_type;

   // r and b in the low half, g moved to the high half, with guard gaps
   localparam lane_type LANE_MASK = 32'h07E0_F81F;

   localparam coverage_type COV_CLEAR  = 4'd0;
   localparam coverage_type COV_OPAQUE = 4'd15;
   localparam logic [4:0]   OPA_SCALE  = 5'd17;
   localparam logic [8:0]   OPA_ROUND  = 9'd4;

   localparam csr_index_type REG_FG_COLOR    = 4'd0;
   localparam csr_index_type REG_CLIP_LEFT   = 4'd1;
   localparam csr_index_type REG_CLIP_TOP    = 4'd2;
   localparam csr_index_type REG_CLIP_RIGHT  = 4'd3;
   localparam csr_index_type REG_CLIP_BOTTOM = 4'd4;
   localparam csr_index_type REG_ORIGIN_X    = 4'd5;
   localparam csr_index_type REG_ORIGIN_Y    = 4'd6;
   localparam csr_index_type REG_BOX_WIDTH   = 4'd7;

endpackage

FILE: rtl/gcbb_blend.sv
// rgb565 foreground over background mix, all three channels in one lane word
module gcbb_blend (
   input  gcbb_pkg::rgb565_type   fg_color,
   input  gcbb_pkg::rgb565_type   background,
   input  gcbb_pkg::coverage_type coverage,
   output gcbb_pkg::rgb565_type   blend_pixel
);
   import gcbb_pkg::*;

   logic [7:0]  opacity;
   logic [8:0]  opa_round;
   logic [5:0]  weight;
   lane_type    fg_lane;
   lane_type    bg_lane;
   lane_type    diff_lane;
   lane_type    prod_lane;
   lane_type    mix_lane;

   always_comb begin
      opacity   = 8'(coverage * OPA_SCALE);
      opa_round = {1'b0, opacity} + OPA_ROUND;
      weight    = opa_round[8:3];
      fg_lane   = {fg_color, fg_color} & LANE_MASK;
      bg_lane   = {background, background} & LANE_MASK;
      diff_lane = fg_lane - bg_lane;
      prod_lane = 32'(diff_lane * {26'd0, weight});
      mix_lane  = ({5'd0, prod_lane[31:5]} + bg_lane) & LANE_MASK;
      blend_pixel = mix_lane[31:16] | mix_lane[15:0];
   end

endmodule

FILE: rtl/glyph_coverage_blend_blit_core.sv
// top level of the glyph coverage blend blitter
//
// usage:
// - req channel: one 4-bit glyph coverage value per transaction in raster order,
//   with the framebuffer pixel under it; req_first_pixel restarts at row 0,
//   column 0 of the glyph box
// - rsp channel: one transaction per request with the screen position, a write
//   enable and the pixel value to store (background when not written)
// - csr channel: register writes by index, always ready; write only while the
//   block is idle
// - a request accepted into the input stage moves on into the result register
//   once that register is free, and is then offered on rsp; throughput is one
//   transaction per cycle while rsp is not stalled, since both register stages
//   hand on a transaction every cycle
// - column and row tracking advance at request acceptance, so consecutive
//   transactions never wait on each other
// - rsp_stall holds the result register; an empty input stage still takes one
//   more transaction, then req_stall rises until the result moves on
// - reset (synchronous) empties both stages, zeroes column and row and
//   loads the register defaults (white foreground, clip box 320 by 240)
module glyph_coverage_blend_blit_core #(
   parameter int FB_WIDTH  = 320,
   parameter int FB_HEIGHT = 240
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  gcbb_pkg::coverage_type  req_coverage,
   input  gcbb_pkg::rgb565_type    req_background,
   input  logic                    req_first_pixel,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_write_enable,
   output logic signed [11:0]      rsp_screen_x,
   output logic signed [11:0]      rsp_screen_y,
   output gcbb_pkg::rgb565_type    rsp_new_pixel,
   // configuration write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  gcbb_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_wdata
);
   import gcbb_pkg::*;

   localparam logic [10:0] FB_RIGHT  = 11'(FB_WIDTH);
   localparam logic [10:0] FB_BOTTOM = 11'(FB_HEIGHT);

   // configuration registers
   rgb565_type         fg_color_ff;
   logic [10:0]        clip_left_ff, clip_top_ff, clip_right_ff, clip_bottom_ff;
   logic signed [10:0] origin_x_ff, origin_y_ff;
   logic [7:0]         box_width_ff;

   // glyph box position of the next transaction
   logic [7:0] column_count_ff, column_count_in;
   logic [7:0] row_count_ff, row_count_in;

   // input stage
   logic         s1_valid_ff, s1_valid_in;
   coverage_type s1_coverage_ff;
   rgb565_type   s1_background_ff;
   logic [7:0]   s1_column_ff, s1_row_ff;

   // result stage
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_write_enable_ff, rsp_write_enable_in;
   logic signed [11:0] rsp_screen_x_ff, rsp_screen_x_in;
   logic signed [11:0] rsp_screen_y_ff, rsp_screen_y_in;
   rgb565_type        rsp_new_pixel_ff, rsp_new_pixel_in;

   logic       out_free;
   logic       req_accept;
   logic [7:0] column_use, row_use;
   logic [7:0] width_eff;
   logic [8:0] column_next;
   logic [10:0] clip_right_eff, clip_bottom_eff;
   logic       in_clip;
   rgb565_type blend_pixel;

   assign csr_ready = 1'b1;

   // handshake: result register frees when empty or being taken
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   // position tracking, done at acceptance
   always_comb begin
      column_use  = req_first_pixel ? 8'd0 : column_count_ff;
      row_use     = req_first_pixel ? 8'd0 : row_count_ff;
      // zero width behaves as one column per row
      width_eff   = (box_width_ff == 8'd0) ? 8'd1 : box_width_ff;
      column_next = {1'b0, column_use} + 9'd1;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (req_accept) begin
         // also catches a column left beyond a newly narrowed box
         if (column_next >= {1'b0, width_eff}) begin
            column_count_in = 8'd0;
            row_count_in    = row_use + 8'd1;
         end else begin
            column_count_in = column_next[7:0];
            row_count_in    = row_use;
         end
      end
   end

   assign s1_valid_in = req_accept ? 1'b1 : (out_free ? 1'b0 : s1_valid_ff);

   gcbb_blend u_blend (
      .fg_color    (fg_color_ff),
      .background  (s1_background_ff),
      .coverage    (s1_coverage_ff),
      .blend_pixel (blend_pixel)
   );

   // screen position, clip test and pixel select for the input stage
   always_comb begin
      rsp_screen_x_in = {origin_x_ff[10], origin_x_ff} + $signed({4'd0, s1_column_ff});
      rsp_screen_y_in = {origin_y_ff[10], origin_y_ff} + $signed({4'd0, s1_row_ff});
      clip_right_eff  = (clip_right_ff < FB_RIGHT) ? clip_right_ff : FB_RIGHT;
      clip_bottom_eff = (clip_bottom_ff < FB_BOTTOM) ? clip_bottom_ff : FB_BOTTOM;
      in_clip = ($signed({rsp_screen_x_in[11], rsp_screen_x_in}) >=
                 $signed({2'b00, clip_left_ff})) &&
                ($signed({rsp_screen_x_in[11], rsp_screen_x_in}) <
                 $signed({2'b00, clip_right_eff})) &&
                ($signed({rsp_screen_y_in[11], rsp_screen_y_in}) >=
                 $signed({2'b00, clip_top_ff})) &&
                ($signed({rsp_screen_y_in[11], rsp_screen_y_in}) <
                 $signed({2'b00, clip_bottom_eff}));
      rsp_write_enable_in = in_clip && (s1_coverage_ff != COV_CLEAR);
      priority if (!rsp_write_enable_in) begin
         rsp_new_pixel_in = s1_background_ff;
      end else if (s1_coverage_ff == COV_OPAQUE) begin
         rsp_new_pixel_in = fg_color_ff;
      end else begin
         rsp_new_pixel_in = blend_pixel;
      end
   end

   assign rsp_valid_in = out_free ? s1_valid_ff : 1'b1;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         column_count_ff <= 8'd0;
         row_count_ff    <= 8'd0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff    <= 16'hFFFF;
         clip_left_ff   <= 11'd0;
         clip_top_ff    <= 11'd0;
         clip_right_ff  <= 11'd320;
         clip_bottom_ff <= 11'd240;
         origin_x_ff    <= 11'sd0;
         origin_y_ff    <= 11'sd0;
         box_width_ff   <= 8'd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_FG_COLOR:    fg_color_ff    <= csr_wdata;
            REG_CLIP_LEFT:   clip_left_ff   <= csr_wdata[10:0];
            REG_CLIP_TOP:    clip_top_ff    <= csr_wdata[10:0];
            REG_CLIP_RIGHT:  clip_right_ff  <= csr_wdata[10:0];
            REG_CLIP_BOTTOM: clip_bottom_ff <= csr_wdata[10:0];
            REG_ORIGIN_X:    origin_x_ff    <= $signed(csr_wdata[10:0]);
            REG_ORIGIN_Y:    origin_y_ff    <= $signed(csr_wdata[10:0]);
            REG_BOX_WIDTH:   box_width_ff   <= csr_wdata[7:0];
            default: begin
               // unmapped index: write is dropped
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_coverage_ff   <= req_coverage;
         s1_background_ff <= req_background;
         s1_column_ff     <= column_use;
         s1_row_ff        <= row_use;
      end
      if (out_free && s1_valid_ff) begin
         rsp_write_enable_ff <= rsp_write_enable_in;
         rsp_screen_x_ff     <= rsp_screen_x_in;
         rsp_screen_y_ff     <= rsp_screen_y_in;
         rsp_new_pixel_ff    <= rsp_new_pixel_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = rsp_write_enable_ff;
   assign rsp_screen_x     = rsp_screen_x_ff;
   assign rsp_screen_y     = rsp_screen_y_ff;
   assign rsp_new_pixel    = rsp_new_pixel_ff;

endmodule

FILE: rtl/gcbb_checker.sv
// port-level assertions for the glyph coverage blend blitter, with bind
module gcbb_checker #(
   parameter int FB_WIDTH  = 320,
   parameter int FB_HEIGHT = 240
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_write_enable,
   input logic signed [11:0]   rsp_screen_x,
   input logic signed [11:0]   rsp_screen_y,
   input gcbb_pkg::rgb565_type rsp_new_pixel
);
   import gcbb_pkg::*;

   localparam logic signed [12:0] FB_W = 13'(FB_WIDTH);
   localparam logic signed [12:0] FB_H = 13'(FB_HEIGHT);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_pixel) &&
         $stable(rsp_screen_x) && $stable(rsp_screen_y) && $stable(rsp_write_enable))
      else $error("stalled result changed");

   // reset empties the result stage
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a write lands inside the frame horizontally
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_enable |->
         $signed({rsp_screen_x[11], rsp_screen_x}) >= 13'sd0 &&
         $signed({rsp_screen_x[11], rsp_screen_x}) < FB_W)
      else $error("write outside frame columns");

   // a write lands inside the frame vertically
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_enable |->
         $signed({rsp_screen_y[11], rsp_screen_y}) >= 13'sd0 &&
         $signed({rsp_screen_y[11], rsp_screen_y}) < FB_H)
      else $error("write outside frame rows");

endmodule

bind glyph_coverage_blend_blit_core gcbb_checker #(
   .FB_WIDTH  (FB_WIDTH),
   .FB_HEIGHT (FB_HEIGHT)
) u_gcbb_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_write_enable (rsp_write_enable),
   .rsp_screen_x     (rsp_screen_x),
   .rsp_screen_y     (rsp_screen_y),
   .rsp_new_pixel    (rsp_new_pixel)
);

FILE: tb/gcbb_blit_tracker.sv
// passive observer of the blitter channels: predicts each blit write and compares results
module gcbb_blit_tracker #(
   parameter int FB_WIDTH  = 320,
   parameter int FB_HEIGHT = 240
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  gcbb_pkg::coverage_type  req_coverage,
   input  gcbb_pkg::rgb565_type    req_background,
   input  logic                    req_first_pixel,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic                    rsp_write_enable,
   input  logic signed [11:0]      rsp_screen_x,
   input  logic signed [11:0]      rsp_screen_y,
   input  gcbb_pkg::rgb565_type    rsp_new_pixel,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  gcbb_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_wdata,
   output int                      mismatch_count,
   output int                      pending_pixels
);
   timeunit 1ns;
   timeprecision 1ps;
   import gcbb_pkg::*;

   typedef struct {
      logic               write_enable;
      logic signed [11:0] screen_x;
      logic signed [11:0] screen_y;
      rgb565_type         new_pixel;
   } blit_write_type;

   blit_write_type     pending_writes[$];
   int                 errors = 0;

   rgb565_type         fg_color;
   logic [10:0]        clip_left, clip_top, clip_right, clip_bottom;
   logic signed [10:0] origin_x, origin_y;
   logic [7:0]         box_width;
   logic [7:0]         glyph_col, glyph_row;

   assign mismatch_count = errors;

   // rgb565 blend of all three channels in one lane word
   function automatic rgb565_type blend_565(rgb565_type fg, rgb565_type bg, coverage_type cov);
      lane_type f, b, r, weight;
      weight = lane_type'((int'(cov) * int'(OPA_SCALE) + int'(OPA_ROUND)) >> 3);
      f = {fg, fg} & LANE_MASK;
      b = {bg, bg} & LANE_MASK;
      r = ((((f - b) * weight) >> 5) + b) & LANE_MASK;
      return r[31:16] | r[15:0];
   endfunction

   always @(posedge clock) begin
      blit_write_type want;
      int x, y, right_edge, bottom_edge, width;
      logic in_clip;
      if (reset) begin
         fg_color    = 16'hFFFF;
         clip_left   = '0;
         clip_top    = '0;
         clip_right  = 11'd320;
         clip_bottom = 11'd240;
         origin_x    = '0;
         origin_y    = '0;
         box_width   = 8'd1;
         glyph_col   = '0;
         glyph_row   = '0;
         pending_writes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FG_COLOR:    fg_color    = csr_wdata;
               REG_CLIP_LEFT:   clip_left   = csr_wdata[10:0];
               REG_CLIP_TOP:    clip_top    = csr_wdata[10:0];
               REG_CLIP_RIGHT:  clip_right  = csr_wdata[10:0];
               REG_CLIP_BOTTOM: clip_bottom = csr_wdata[10:0];
               REG_ORIGIN_X:    origin_x    = csr_wdata[10:0];
               REG_ORIGIN_Y:    origin_y    = csr_wdata[10:0];
               REG_BOX_WIDTH:   box_width   = csr_wdata[7:0];
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (pending_writes.size() == 0) begin
               $error("result with no pending pixel: x=%0d y=%0d", rsp_screen_x, rsp_screen_y);
               errors++;
            end else begin
               want = pending_writes.pop_front();
               if (rsp_write_enable !== want.write_enable) begin
                  $error("write_enable: expected %0d, actual %0d",
                         want.write_enable, rsp_write_enable);
                  errors++;
               end
               if (rsp_screen_x !== want.screen_x) begin
                  $error("screen_x: expected %0d, actual %0d", want.screen_x, rsp_screen_x);
                  errors++;
               end
               if (rsp_screen_y !== want.screen_y) begin
                  $error("screen_y: expected %0d, actual %0d", want.screen_y, rsp_screen_y);
                  errors++;
               end
               if (rsp_new_pixel !== want.new_pixel) begin
                  $error("new_pixel: expected %h, actual %h", want.new_pixel, rsp_new_pixel);
                  errors++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            if (req_first_pixel) begin
               glyph_col = '0;
               glyph_row = '0;
            end
            x = int'(origin_x) + int'(glyph_col);
            y = int'(origin_y) + int'(glyph_row);
            right_edge  = (int'(clip_right) < FB_WIDTH) ? int'(clip_right) : FB_WIDTH;
            bottom_edge = (int'(clip_bottom) < FB_HEIGHT) ? int'(clip_bottom) : FB_HEIGHT;
            in_clip = (x >= int'(clip_left)) && (x < right_edge) &&
                      (y >= int'(clip_top)) && (y < bottom_edge);
            want.write_enable = in_clip && (req_coverage != COV_CLEAR);
            want.screen_x = 12'(x);
            want.screen_y = 12'(y);
            if (!want.write_enable)
               want.new_pixel = req_background;
            else if (req_coverage == COV_OPAQUE)
               want.new_pixel = fg_color;
            else
               want.new_pixel = blend_565(fg_color, req_background, req_coverage);
            pending_writes.push_back(want);

            // raster advance, zero width behaves as one
            width = (box_width == 0) ? 1 : int'(box_width);
            if (int'(glyph_col) + 1 >= width) begin
               glyph_col = '0;
               glyph_row = glyph_row + 8'd1;
            end else begin
               glyph_col = glyph_col + 8'd1;
            end
         end
      end
      pending_pixels <= pending_writes.size();
   end

endmodule

FILE: tb/glyph_coverage_blend_blit_core_tb.sv
// top of the glyph blitter testbench: clock, reset, stimulus and verdict
module glyph_coverage_blend_blit_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gcbb_pkg::*;

   localparam int FB_WIDTH      = 320;
   localparam int FB_HEIGHT     = 240;
   localparam int STALL_LIMIT   = 2000;  // cycles with no transaction before giving up
   localparam int SETTLE_CYCLES = 4;     // two register stages plus margin
   localparam int RANDOM_PHASES = 11;
   localparam int PHASE_PIXELS  = 70;
   localparam int WRAP_PIXELS   = 280;   // long enough for the row counter to wrap

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   coverage_type       req_coverage = '0;
   rgb565_type         req_background = '0;
   logic               req_first_pixel = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_write_enable;
   logic signed [11:0] rsp_screen_x;
   logic signed [11:0] rsp_screen_y;
   rgb565_type         rsp_new_pixel;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   csr_index_type      csr_index = REG_FG_COLOR;
   logic [15:0]        csr_wdata = '0;

   int mismatch_count;
   int pending_pixels;
   int glyph_width = 1;   // effective columns per row as last programmed
   int burst_left = 0;
   int idle_cycles = 0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   glyph_coverage_blend_blit_core #(
      .FB_WIDTH  (FB_WIDTH),
      .FB_HEIGHT (FB_HEIGHT)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_coverage     (req_coverage),
      .req_background   (req_background),
      .req_first_pixel  (req_first_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_write_enable (rsp_write_enable),
      .rsp_screen_x     (rsp_screen_x),
      .rsp_screen_y     (rsp_screen_y),
      .rsp_new_pixel    (rsp_new_pixel),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   gcbb_blit_tracker #(
      .FB_WIDTH  (FB_WIDTH),
      .FB_HEIGHT (FB_HEIGHT)
   ) u_tracker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_coverage     (req_coverage),
      .req_background   (req_background),
      .req_first_pixel  (req_first_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_write_enable (rsp_write_enable),
      .rsp_screen_x     (rsp_screen_x),
      .rsp_screen_y     (rsp_screen_y),
      .rsp_new_pixel    (rsp_new_pixel),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .pending_pixels   (pending_pixels)
   );

   // result side backpressure: modes held for a random stretch
   // free flow, light random, fixed pattern, heavy random
   int stall_mode = 0;
   int stall_hold = 0;
   int stall_phase = 0;
   always @(negedge clock) begin
      if (stall_hold == 0) begin
         stall_mode  = $urandom_range(0, 3);
         stall_hold  = $urandom_range(20, 200);
         stall_phase = 0;
      end else begin
         stall_hold--;
         stall_phase++;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ((stall_phase % 5) < 2);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // one register write, csr_valid dropped again once the write is taken
   task automatic write_reg(input csr_index_type idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_blit(input int fg, input int cl, input int ct, input int cr,
                               input int cb, input int ox, input int oy, input int bw);
      write_reg(REG_FG_COLOR, fg);
      write_reg(REG_CLIP_LEFT, cl);
      write_reg(REG_CLIP_TOP, ct);
      write_reg(REG_CLIP_RIGHT, cr);
      write_reg(REG_CLIP_BOTTOM, cb);
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_BOX_WIDTH, bw);
      glyph_width = (bw == 0) ? 1 : bw;
   endtask

   // hold requests off until every pending pixel has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_pixels != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // one request transaction, then maybe a gap when the burst runs out
   task automatic send_pixel(input coverage_type cov, input rgb565_type bg, input logic first);
      int gap;
      req_valid       <= 1'b1;
      req_coverage    <= cov;
      req_background  <= bg;
      req_first_pixel <= first;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // clear and opaque weighted up, rest spread over the blend range
   function automatic coverage_type pick_coverage();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return COV_CLEAR;
      else if (pick == 1)
         return COV_OPAQUE;
      else
         return coverage_type'($urandom_range(1, 14));
   endfunction

   // one well-formed glyph box in raster order
   task automatic draw_glyph(input int rows);
      for (int r = 0; r < rows; r++)
         for (int c = 0; c < glyph_width; c++)
            send_pixel(pick_coverage(), 16'($urandom), (r == 0) && (c == 0));
   endtask

   function automatic int pick_edge(input int span);
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0)
         return 0;
      else if (pick == 1)
         return 1024;
      else
         return $urandom_range(0, span);
   endfunction

   task automatic program_random();
      int fg, cl, ct, cr, cb, ox, oy, bw, pick;
      pick = $urandom_range(0, 7);
      fg = (pick == 0) ? 0 : (pick == 1) ? 16'hFFFF : int'($urandom_range(0, 65535));
      cl = pick_edge(200);
      ct = pick_edge(150);
      // right and bottom edges mostly past the near edge, sometimes inverted or full
      pick = $urandom_range(0, 7);
      cr = (pick == 0) ? 1024 : (pick == 1) ? 0 : cl + int'($urandom_range(0, 300));
      if (cr > 1024) cr = 1024;
      pick = $urandom_range(0, 7);
      cb = (pick == 0) ? 1024 : (pick == 1) ? 0 : ct + int'($urandom_range(0, 200));
      if (cb > 1024) cb = 1024;
      pick = $urandom_range(0, 7);
      ox = (pick == 0) ? -1024 : (pick == 1) ? 1023 : int'($urandom_range(0, 370)) - 40;
      pick = $urandom_range(0, 7);
      oy = (pick == 0) ? -1024 : (pick == 1) ? 1023 : int'($urandom_range(0, 290)) - 40;
      pick = $urandom_range(0, 11);
      bw = (pick == 0) ? 255 : (pick == 1) ? 0 : int'($urandom_range(1, 24));
      program_blit(fg, cl, ct, cr, cb, ox, oy, bw);
   endtask

   // mostly whole glyphs, some noise with stray or missing restarts
   task automatic run_random_phase();
      int sent, rows, row_cap, count;
      sent = 0;
      program_random();
      while (sent < PHASE_PIXELS) begin
         if ($urandom_range(0, 4) != 0) begin
            row_cap = 60 / glyph_width;
            if (row_cap < 1) row_cap = 1;
            rows = $urandom_range(1, row_cap);
            draw_glyph(rows);
            sent += rows * glyph_width;
         end else begin
            count = $urandom_range(1, 6);
            for (int i = 0; i < count; i++)
               send_pixel(coverage_type'($urandom_range(0, 15)), 16'($urandom),
                          $urandom_range(0, 3) == 0);
            sent += count;
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: white foreground, frame-sized clip, one column per row
      send_pixel(COV_OPAQUE, 16'h0000, 1'b1);
      send_pixel(COV_CLEAR, 16'hFFFF, 1'b0);
      send_pixel(4'd1, 16'h0000, 1'b0);
      send_pixel(4'd14, 16'hFFFF, 1'b0);
      send_pixel(4'd8, 16'hA5A5, 1'b0);
      wait_idle();

      // most negative origin, everything left and above the clip box
      program_blit(16'h0000, 0, 0, 1024, 1024, -1024, -1024, 255);
      send_pixel(COV_OPAQUE, 16'h1234, 1'b1);
      send_pixel(4'd3, 16'hFFFF, 1'b0);
      wait_idle();

      // empty clip box at its far corner, zero box width
      program_blit(16'h07E0, 1024, 1024, 1024, 1024, 1023, 1023, 0);
      send_pixel(COV_OPAQUE, 16'h0000, 1'b1);
      send_pixel(4'd9, 16'h8421, 1'b0);
      wait_idle();

      // row crossing the left and right clip edges
      program_blit(16'hF81F, 12, 8, 20, 20, 10, 8, 20);
      for (int i = 0; i < 12; i++)
         send_pixel(coverage_type'(i + 4), 16'($urandom), i == 0);
      wait_idle();

      // narrow the box with the column already past it
      write_reg(REG_BOX_WIDTH, 4);
      glyph_width = 4;
      for (int i = 0; i < 3; i++)
         send_pixel(COV_OPAQUE, 16'h0F0F, 1'b0);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         run_random_phase();
         if (p == RANDOM_PHASES / 2) begin
            // one long column, row counter wraps back to the top
            program_blit(int'($urandom_range(0, 65535)), 0, 0, 1024, 1024,
                         int'($urandom_range(0, 300)), -100, $urandom_range(0, 1));
            for (int i = 0; i < WRAP_PIXELS; i++)
               send_pixel(pick_coverage(), 16'($urandom), i == 0);
            wait_idle();
         end
      end

      if (mismatch_count == 0 && pending_pixels == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
